FILE: src/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IN_RATE  = 24000;
  localparam int OUT_RATE = 44100;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t prev;
    sample_t cur;
    logic    fin;
  } smp_pair_t;

endpackage

FILE: src/lir_in_if.sv
`timescale 1ns / 1ps

interface lir_in_if;
  logic              valid;
  logic              ready;
  lir_pkg::sample_t  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

FILE: src/lir_out_if.sv
`timescale 1ns / 1ps

interface lir_out_if;
  logic              valid;
  logic              ready;
  lir_pkg::sample_t  left_out;
  lir_pkg::sample_t  right_out;
  logic              final_pair;

  modport source (output valid, output left_out, output right_out, output final_pair,
                  input ready);
  modport sink (input valid, input left_out, input right_out, input final_pair,
                output ready);
endinterface

FILE: src/lir_cfg_if.sv
`timescale 1ns / 1ps

interface lir_cfg_if #(
  parameter int PHASE_FRAC_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [PHASE_FRAC_BITS:0] phase_step;

  modport source (output valid, output phase_step, input ready);
  modport sink (input valid, input phase_step, output ready);
endinterface

FILE: src/lir_front.sv
`timescale 1ns / 1ps

module lir_front #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lir_in_if.sink                      in_ch,
  lir_cfg_if.sink                     cfg_ch,
  output logic                        job_valid,
  input  logic                        job_ready,
  output lir_pkg::smp_pair_t          job_smp,
  output logic [PHASE_FRAC_BITS-1:0]  job_phase
);

  localparam int F = PHASE_FRAC_BITS;
  localparam logic [F:0] PhOne  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] PhHalf = {2'b01, {(F-1){1'b0}}};
  localparam longint StepRstVal = ((longint'(lir_pkg::IN_RATE) << F)
                                   + longint'(lir_pkg::OUT_RATE / 2))
                                  / longint'(lir_pkg::OUT_RATE);
  localparam logic [F:0] StepRst = StepRstVal[F:0];

  logic [F:0]         step_r, step_nxt;
  logic [F-1:0]       phase_r, phase_nxt;
  lir_pkg::sample_t   held_r, held_nxt;
  logic               fr_vld_r, fr_vld_nxt;
  logic               fr_two_r, fr_two_nxt;
  logic               fr_fst_r, fr_fst_nxt;
  lir_pkg::sample_t   fr_prev_r, fr_prev_nxt;
  lir_pkg::sample_t   fr_cur_r, fr_cur_nxt;
  logic [F-1:0]       fr_p_r, fr_p_nxt;
  logic [F-1:0]       fr_p2_r, fr_p2_nxt;

  logic [F:0]         step_c;
  logic [F:0]         sum1;
  logic               two;
  logic               push;
  logic               acc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !fr_vld_r || (job_ready && !fr_two_r);
  assign acc          = in_ch.valid && in_ch.ready;
  assign push         = fr_vld_r && job_ready;

  assign job_valid     = fr_vld_r;
  assign job_smp.prev  = fr_prev_r;
  assign job_smp.cur   = fr_cur_r;
  assign job_smp.fin   = !fr_two_r;
  assign job_phase     = fr_p_r;

  always_comb begin
    priority if (step_r < PhHalf) begin
      step_c = PhHalf;
    end else if (step_r > PhOne) begin
      step_c = PhOne;
    end else begin
      step_c = step_r;
    end
  end

  assign sum1 = {1'b0, phase_r} + step_c;
  assign two  = !sum1[F];

  always_comb begin
    step_nxt    = step_r;
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    fr_vld_nxt  = fr_vld_r;
    fr_two_nxt  = fr_two_r;
    fr_fst_nxt  = fr_fst_r;
    fr_prev_nxt = fr_prev_r;
    fr_cur_nxt  = fr_cur_r;
    fr_p_nxt    = fr_p_r;
    fr_p2_nxt   = fr_p2_r;
    if (cfg_ch.valid) begin
      step_nxt = cfg_ch.phase_step;
    end
    if (push) begin
      fr_fst_nxt = 1'b0;
      if (fr_two_r) begin
        fr_two_nxt = 1'b0;
        fr_p_nxt   = fr_p2_r;
      end else begin
        fr_vld_nxt = 1'b0;
      end
    end
    if (acc) begin
      fr_vld_nxt  = 1'b1;
      fr_fst_nxt  = 1'b1;
      fr_two_nxt  = two;
      fr_prev_nxt = held_r;
      fr_cur_nxt  = in_ch.sample_in;
      fr_p_nxt    = phase_r;
      fr_p2_nxt   = sum1[F-1:0];
      held_nxt    = in_ch.sample_in;
      phase_nxt   = two ? (sum1[F-1:0] + step_c[F-1:0]) : sum1[F-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= StepRst;
      phase_r  <= '0;
      held_r   <= '0;
      fr_vld_r <= 1'b0;
      fr_two_r <= 1'b0;
      fr_fst_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      fr_vld_r <= fr_vld_nxt;
      fr_two_r <= fr_two_nxt;
      fr_fst_r <= fr_fst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_prev_r <= fr_prev_nxt;
    fr_cur_r  <= fr_cur_nxt;
    fr_p_r    <= fr_p_nxt;
    fr_p2_r   <= fr_p2_nxt;
  end

  a_two_needs_vld: assert property (@(posedge clk) disable iff (!rst_n)
    fr_two_r |-> fr_vld_r)
    else $error("second pair pending without a word");

  a_acc_loads: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> fr_vld_r && fr_fst_r)
    else $error("accepted word not held");

  a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    fr_two_r |-> fr_fst_r)
    else $error("second pair pending after first pair left");

endmodule

FILE: src/lir_queue.sv
`timescale 1ns / 1ps

module lir_queue #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  logic [WIDTH-1:0] ent_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt_r != Full);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = ent_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LastIdx) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == LastIdx) ? '0 : rp_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Full)
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == Full) |-> (wp_r == rp_r))
    else $error("queue pointers out of step");

  a_cnt_move: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance");

endmodule

FILE: src/lir_back.sv
`timescale 1ns / 1ps

module lir_back #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  lir_pkg::smp_pair_t          job_smp,
  input  logic [PHASE_FRAC_BITS-1:0]  job_phase,
  lir_out_if.source                   out_ch
);

  localparam int F  = PHASE_FRAC_BITS;
  localparam int SW = lir_pkg::SAMPLE_W;
  localparam int PW = SW + F + 2;
  localparam int QW = PW - F;

  logic                  s1_vld_r, s1_vld_nxt;
  lir_pkg::sample_t      s1_prev_r;
  logic                  s1_fin_r;
  logic signed [PW-1:0]  s1_prod_r;
  logic                  o_vld_r, o_vld_nxt;
  lir_pkg::sample_t      o_smp_r;
  logic                  o_fin_r;

  logic signed [SW:0]    diff;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  base;
  logic signed [PW-1:0]  num;
  logic signed [QW-1:0]  quo;
  logic                  rnd;
  logic signed [QW-1:0]  res;
  logic                  s1_load;
  logic                  o_load;

  assign diff = {job_smp.cur[SW-1], job_smp.cur} - {job_smp.prev[SW-1], job_smp.prev};
  assign prod = PW'(diff * $signed({1'b0, job_phase}));

  assign base = {{2{s1_prev_r[SW-1]}}, s1_prev_r, {F{1'b0}}};
  assign num  = base + s1_prod_r;
  assign quo  = num[PW-1:F];
  assign rnd  = num[PW-1] && (num[F-1:0] != '0);
  assign res  = quo + QW'(rnd);

  assign o_load    = s1_vld_r && (!o_vld_r || out_ch.ready);
  assign job_ready = !s1_vld_r || o_load;
  assign s1_load   = job_valid && job_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    o_vld_nxt  = o_vld_r;
    if (s1_load) begin
      s1_vld_nxt = 1'b1;
    end else if (o_load) begin
      s1_vld_nxt = 1'b0;
    end
    if (o_load) begin
      o_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      o_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_prev_r <= job_smp.prev;
      s1_fin_r  <= job_smp.fin;
      s1_prod_r <= prod;
    end
    if (o_load) begin
      o_smp_r <= res[SW-1:0];
      o_fin_r <= s1_fin_r;
    end
  end

  assign out_ch.valid      = o_vld_r;
  assign out_ch.left_out   = o_smp_r;
  assign out_ch.right_out  = o_smp_r;
  assign out_ch.final_pair = o_fin_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && !out_ch.ready) |=> o_vld_r && $stable(o_smp_r))
    else $error("stalled pair changed");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !o_load) |=> s1_vld_r && $stable(s1_prod_r))
    else $error("product stage lost a pair");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_load |-> (res[QW-1:SW-1] == '0 || res[QW-1:SW-1] == '1))
    else $error("interpolated value outside sample range");

endmodule

FILE: src/linear_interp_resampler.sv
`timescale 1ns / 1ps

// Channel  Port    Dir  Fields
// input    in_ch   in   sample_in (s16)
// result   out_ch  out  left_out (s16), right_out (s16), final_pair (1)
// config   cfg_ch  in   phase_step (PHASE_FRAC_BITS+1, unsigned, Q1.F)
//
// Each word in gives one or two pairs; the front issues one pair per cycle while
// the queue is ready, and its single word slot takes the next word as the last
// pair of the current one leaves. A pair passes the front register, the queue,
// the product register and the output register on its way to out_ch. rst_n is
// synchronous: phase and held sample clear, step returns to 24000/44100. A stall
// on out_ch backs up through the two-entry queue; cfg_ch is always ready.

module linear_interp_resampler #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lir_in_if.sink     in_ch,
  lir_out_if.source  out_ch,
  lir_cfg_if.sink    cfg_ch
);

  localparam int JW = $bits(lir_pkg::smp_pair_t) + PHASE_FRAC_BITS;

  logic                        fj_valid;
  logic                        fj_ready;
  lir_pkg::smp_pair_t          fj_smp;
  logic [PHASE_FRAC_BITS-1:0]  fj_phase;
  logic                        bj_valid;
  logic                        bj_ready;
  logic [JW-1:0]               bj_data;
  lir_pkg::smp_pair_t          bj_smp;
  logic [PHASE_FRAC_BITS-1:0]  bj_phase;

  lir_front #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job_smp   (fj_smp),
    .job_phase (fj_phase)
  );

  lir_queue #(
    .WIDTH (JW),
    .DEPTH (2)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  ({fj_smp, fj_phase}),
    .rd_valid (bj_valid),
    .rd_ready (bj_ready),
    .rd_data  (bj_data)
  );

  assign bj_smp   = bj_data[JW-1:PHASE_FRAC_BITS];
  assign bj_phase = bj_data[PHASE_FRAC_BITS-1:0];

  lir_back #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job_smp   (bj_smp),
    .job_phase (bj_phase),
    .out_ch    (out_ch)
  );

endmodule
